@@ src/irss_pkg.sv @@
// Shared types and constants for the imager run/stop sequencer.
// No dependencies; imported by irss_decide and imager_run_stop_sequencer.
package irss_pkg;

  localparam int unsigned OpW   = 3;
  localparam int unsigned RegW  = 2;
  localparam int unsigned ValW  = 16;
  localparam int unsigned PcntW = 8;

  typedef enum logic [OpW-1:0] {
    OP_RUN_CAM = 3'd0,
    OP_RUN_SNS = 3'd1,
    OP_WR_DONE = 3'd2,
    OP_RD_DONE = 3'd3,
    OP_TIMER   = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ACT_NONE  = 3'd0,
    ACT_WRITE = 3'd1,
    ACT_READ  = 3'd2,
    ACT_TIMER = 3'd3,
    ACT_DONE  = 3'd4
  } action_e;

  typedef enum logic [RegW-1:0] {
    REG_CTRL  = 2'd0,
    REG_SNS   = 2'd1,
    REG_STAT  = 2'd2,
    REG_OTHER = 2'd3
  } reg_e;

  // Config register indexes
  localparam logic CFG_POLL_MAX   = 1'b0;
  localparam logic CFG_POLL_DELAY = 1'b1;

  localparam logic [ValW-1:0]  SensorBusyBit = 16'h0002;
  localparam logic [ValW-1:0]  ProcIdleBits  = 16'h0070;
  localparam logic [ValW-1:0]  ModRunVal     = 16'h0001;
  localparam logic [ValW-1:0]  ModStopVal    = 16'h0000;
  localparam logic [ValW-1:0]  SnsRunVal     = 16'h0024;
  localparam logic [ValW-1:0]  SnsStopVal    = 16'h0020;
  localparam logic [ValW-1:0]  PollDelayRst  = 16'd50;
  localparam logic [PcntW-1:0] PollMaxRst    = 8'd16;

  typedef struct packed {
    logic [OpW-1:0]  operation;
    logic            run_request;
    logic [RegW-1:0] reg_id;
    logic [ValW-1:0] reg_value;
    logic            access_ok;
  } item_t;

  typedef struct packed {
    logic [2:0]      action;
    logic [RegW-1:0] target_reg;
    logic [ValW-1:0] write_value;
    logic [ValW-1:0] timer_delay;
    logic            done_unit;
    logic            done_ok;
    logic            done_run;
  } result_t;

  typedef struct packed {
    logic             cam_active;
    logic             sns_active;
    logic             target;     // 0 module, 1 sensor
    logic [RegW-1:0]  polled_reg;
    logic [PcntW-1:0] poll_cnt;
  } seq_state_t;

endpackage

@@ src/irss_decide.sv @@
// Combinational decision logic: one event plus current sequencer state in,
// one result (or none) and next state out. Depends on irss_pkg.
module irss_decide import irss_pkg::*; (
  input  item_t             item_i,
  input  seq_state_t        state_i,
  input  logic [PcntW-1:0]  poll_budget_i,
  input  logic [ValW-1:0]   poll_gap_i,
  output result_t           result_o,
  output seq_state_t        state_o
);

  logic fail_run;
  logic poll_limit;

  assign fail_run   = state_i.target ? state_i.sns_active : state_i.cam_active;
  assign poll_limit = (state_i.poll_cnt >= poll_budget_i);

  always_comb begin
    result_o = '0;
    state_o  = state_i;
    case (op_e'(item_i.operation))
      OP_RUN_CAM: begin
        state_o.target     = 1'b0;
        state_o.poll_cnt   = '0;
        state_o.cam_active = item_i.run_request;
        state_o.sns_active = item_i.run_request;
        result_o.action      = ACT_WRITE;
        result_o.target_reg  = REG_CTRL;
        result_o.write_value = item_i.run_request ? ModRunVal : ModStopVal;
      end
      OP_RUN_SNS: begin
        state_o.target   = 1'b1;
        state_o.poll_cnt = '0;
        if (item_i.run_request == state_i.sns_active) begin
          result_o.action    = ACT_DONE;
          result_o.done_unit = 1'b1;
          result_o.done_ok   = 1'b1;
          result_o.done_run  = item_i.run_request;
        end else begin
          state_o.sns_active   = item_i.run_request;
          result_o.action      = ACT_WRITE;
          result_o.target_reg  = REG_SNS;
          result_o.write_value = item_i.run_request ? SnsRunVal : SnsStopVal;
        end
      end
      OP_WR_DONE, OP_RD_DONE: begin
        if (!item_i.access_ok) begin
          result_o.action    = ACT_DONE;
          result_o.done_unit = state_i.target;
          result_o.done_run  = fail_run;
        end else if (op_e'(item_i.operation) == OP_WR_DONE) begin
          case (reg_e'(item_i.reg_id))
            REG_CTRL: begin
              if (item_i.reg_value == ModStopVal) begin
                result_o.action     = ACT_READ;
                result_o.target_reg = REG_SNS;
              end else begin
                result_o.action   = ACT_DONE;
                result_o.done_ok  = 1'b1;
                result_o.done_run = state_i.cam_active;
              end
            end
            REG_SNS: begin
              if (item_i.reg_value == SnsStopVal) begin
                result_o.action     = ACT_READ;
                result_o.target_reg = REG_SNS;
              end else begin
                result_o.action    = ACT_DONE;
                result_o.done_unit = 1'b1;
                result_o.done_ok   = 1'b1;
                result_o.done_run  = state_i.sns_active;
              end
            end
            default: ;
          endcase
        end else begin
          // read done: decide between done, next read, or another poll
          case (reg_e'(item_i.reg_id))
            REG_SNS: begin
              if ((item_i.reg_value & SensorBusyBit) != '0) begin
                if (poll_limit) begin
                  result_o.action    = ACT_DONE;
                  result_o.done_unit = state_i.target;
                  result_o.done_run  = fail_run;
                end else begin
                  state_o.polled_reg   = REG_SNS;
                  state_o.poll_cnt     = state_i.poll_cnt + PcntW'(1);
                  result_o.action      = ACT_TIMER;
                  result_o.timer_delay = poll_gap_i;
                end
              end else if (!state_i.target) begin
                result_o.action     = ACT_READ;
                result_o.target_reg = REG_STAT;
              end else begin
                result_o.action    = ACT_DONE;
                result_o.done_unit = 1'b1;
                result_o.done_ok   = 1'b1;
                result_o.done_run  = state_i.sns_active;
              end
            end
            REG_STAT: begin
              if ((item_i.reg_value & ProcIdleBits) == ProcIdleBits) begin
                result_o.action   = ACT_DONE;
                result_o.done_ok  = 1'b1;
                result_o.done_run = state_i.cam_active;
              end else if (poll_limit) begin
                result_o.action    = ACT_DONE;
                result_o.done_unit = state_i.target;
                result_o.done_run  = fail_run;
              end else begin
                state_o.polled_reg   = REG_STAT;
                state_o.poll_cnt     = state_i.poll_cnt + PcntW'(1);
                result_o.action      = ACT_TIMER;
                result_o.timer_delay = poll_gap_i;
              end
            end
            default: ;
          endcase
        end
      end
      OP_TIMER: begin
        result_o.action     = ACT_READ;
        result_o.target_reg = state_i.polled_reg;
      end
      default: ;
    endcase
  end

endmodule

@@ src/imager_run_stop_sequencer.sv @@
// Top level of the imager run/stop sequencer: input register, state and
// config registers, result register. Depends on irss_pkg and irss_decide.
//
// Usage:
//   Events (commands, bus write/read completions, timer expiry) enter on the
//   in_valid_i/in_ready_o channel; each beat is one event. Each event gives
//   zero or one result beat on out_valid_o/out_ready_i: a register write, a
//   register read, a timer start, or a done report.
//   Path: an accepted event waits in the input register, is decided there, and
//   its result is caught in the result register, which drives the outputs.
//   Throughput: one event per cycle while out_ready_i does not hold a result,
//   set by the single decision stage between the input and result registers.
//   Stall: while out_ready_i is low and a result is held, the event in the
//   input register waits; in_ready_o drops only once that register is full.
//   Reset: both units recorded as running, module targeted, sensor control
//   register set for polling, poll count 0, poll budget 16, poll gap 50.
//   Config: cfg_we_i writes cfg_data_i into register cfg_idx_i (0 poll
//   budget, 1 poll gap) at once; write only while the block is idle.
module imager_run_stop_sequencer import irss_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_idx_i,
  input  logic [ValW-1:0]  cfg_data_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [OpW-1:0]   operation_i,
  input  logic             run_request_i,
  input  logic [RegW-1:0]  reg_id_i,
  input  logic [ValW-1:0]  reg_value_i,
  input  logic             access_ok_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [2:0]       action_o,
  output logic [RegW-1:0]  target_reg_o,
  output logic [ValW-1:0]  write_value_o,
  output logic [ValW-1:0]  timer_delay_o,
  output logic             done_unit_o,
  output logic             done_ok_o,
  output logic             done_run_o
);

  logic [PcntW-1:0] poll_budget_q;
  logic [ValW-1:0]  poll_gap_q;
  seq_state_t       state_q, state_d;
  item_t            item_q;
  logic             in_full_q;
  result_t          res_q, res_d;
  logic             out_valid_q;
  logic             step;
  logic             out_free;

  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = in_full_q && out_free;
  assign in_ready_o = !in_full_q || step;

  irss_decide u_decide (
    .item_i        (item_q),
    .state_i       (state_q),
    .poll_budget_i (poll_budget_q),
    .poll_gap_i    (poll_gap_q),
    .result_o      (res_d),
    .state_o       (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_budget_q <= PollMaxRst;
      poll_gap_q    <= PollDelayRst;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_POLL_MAX) begin
        poll_budget_q <= cfg_data_i[PcntW-1:0];
      end else begin
        poll_gap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.cam_active <= 1'b1;
      state_q.sns_active <= 1'b1;
      state_q.target     <= 1'b0;
      state_q.polled_reg <= REG_SNS;
      state_q.poll_cnt   <= '0;
    end else if (step) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_ready_o) begin
      in_full_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q.operation   <= operation_i;
      item_q.run_request <= run_request_i;
      item_q.reg_id      <= reg_id_i;
      item_q.reg_value   <= reg_value_i;
      item_q.access_ok   <= access_ok_i;
    end
  end

  // Events with no result (ignored codes or registers) just drop out here.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= step && (action_e'(res_d.action) != ACT_NONE);
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && out_free) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = res_q.action;
  assign target_reg_o  = res_q.target_reg;
  assign write_value_o = res_q.write_value;
  assign timer_delay_o = res_q.timer_delay;
  assign done_unit_o   = res_q.done_unit;
  assign done_ok_o     = res_q.done_ok;
  assign done_run_o    = res_q.done_run;

endmodule
